[rtl/core/json_string_unescape_utf8_unit_macros.svh]
// ----------------------------------------------------------------------------
// JSON string unescape unit: assertion macros
// Shared concurrent assertion forms used by the unescape unit modules.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/core/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescape unit: shared package
// Result types and the character constants of the decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_OK   = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data;
   } result_type;

   // All results caused by one input item; count runs from 0 to 4.
   typedef struct packed {
      logic [2:0]            count;
      result_type [3:0]      res;
   } bundle_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;

   localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
   localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
   localparam logic [15:0] CP_SURR_LO    = 16'hD800;
   localparam logic [15:0] CP_SURR_HI    = 16'hDFFF;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;
   localparam logic [7:0]  UTF8_MASK6    = 8'h3F;

endpackage

[rtl/core/jsu_decode.sv]
// ----------------------------------------------------------------------------
// JSON string unescape unit: decoder
// Input register, parse state and the combinational decode of one byte.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_decode import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_end,
   output logic        bun_valid,
   input  logic        bun_ready,
   output bundle_type  bun
);

   typedef enum logic [1:0] {
      MODE_WAIT,
      MODE_STR,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  byte_ff;
   logic        end_ff;
   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;

   logic        advance;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_next;
   logic [1:0]  n_data;
   logic [7:0]  data0, data1, data2;
   logic        report;
   status_type  report_status;
   logic        closed;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (byte_ff >= 8'h30 && byte_ff <= 8'h39) begin
         hex_val = byte_ff[3:0];
      end else if ((byte_ff >= 8'h61 && byte_ff <= 8'h66) ||
                   (byte_ff >= 8'h41 && byte_ff <= 8'h46)) begin
         hex_val = byte_ff[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cp_next = {code_point_ff[11:0], hex_val};

   // Parse step: data bytes in order, then at most one report.
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      n_data        = 2'd0;
      data0         = byte_ff;
      data1         = 8'd0;
      data2         = 8'd0;
      report        = 1'b0;
      report_status = ST_ERR;
      closed        = 1'b0;
      unique case (mode_ff)
         MODE_WAIT: begin
            if (byte_ff == CH_QUOTE) begin
               mode_in = MODE_STR;
            end else begin
               report = 1'b1;
               closed = 1'b1;
            end
         end
         MODE_STR: begin
            if (byte_ff == CH_QUOTE) begin
               report        = 1'b1;
               report_status = ST_OK;
               closed        = 1'b1;
               mode_in       = MODE_WAIT;
            end else if (byte_ff == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               n_data = 2'd1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_STR;
            n_data  = 2'd1;
            priority case (byte_ff)
               CH_N: data0 = CH_LF;
               CH_R: data0 = CH_CR;
               CH_T: data0 = CH_TAB;
               CH_B: data0 = CH_BS;
               CH_F: data0 = CH_FF;
               CH_U: begin
                  n_data        = 2'd0;
                  mode_in       = MODE_HEX;
                  hex_count_in  = 2'd0;
                  code_point_in = 16'd0;
               end
               default: data0 = byte_ff;
            endcase
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               report  = 1'b1;
               closed  = 1'b1;
               mode_in = MODE_WAIT;
            end else begin
               code_point_in = cp_next;
               if (hex_count_ff == 2'd3) begin
                  hex_count_in = 2'd0;
                  mode_in      = MODE_STR;
                  if (cp_next < CP_TWO_BYTE) begin
                     n_data = 2'd1;
                     data0  = cp_next[7:0];
                  end else if (cp_next < CP_THREE_BYTE) begin
                     n_data = 2'd2;
                     data0  = UTF8_LEAD2 | {3'd0, cp_next[10:6]};
                     data1  = UTF8_CONT | (cp_next[7:0] & UTF8_MASK6);
                  end else if (cp_next >= CP_SURR_LO && cp_next <= CP_SURR_HI) begin
                     n_data = 2'd1;
                     data0  = CH_QMARK;
                  end else begin
                     n_data = 2'd3;
                     data0  = UTF8_LEAD3 | {4'd0, cp_next[15:12]};
                     data1  = UTF8_CONT | {2'd0, cp_next[11:6]};
                     data2  = UTF8_CONT | (cp_next[7:0] & UTF8_MASK6);
                  end
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         default: mode_in = MODE_WAIT;
      endcase
      // Text that ends before the string closes adds an error report.
      if (end_ff && !closed) begin
         report        = 1'b1;
         report_status = ST_ERR;
         mode_in       = MODE_WAIT;
      end
   end

   always_comb begin
      bun                   = '0;
      bun.res[0].data       = data0;
      bun.res[1].data       = data1;
      bun.res[2].data       = data2;
      bun.res[0].status     = ST_DATA;
      bun.res[1].status     = ST_DATA;
      bun.res[2].status     = ST_DATA;
      if (report) begin
         bun.res[n_data].status = report_status;
         bun.res[n_data].data   = 8'd0;
      end
      bun.count = {1'b0, n_data} + {2'd0, report};
   end

   assign bun_valid   = s1_valid_ff && (bun.count != 3'd0);
   assign advance     = s1_valid_ff && ((bun.count == 3'd0) || bun_ready);
   assign in_ready    = !s1_valid_ff || advance;
   assign s1_valid_in = in_valid || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         mode_ff       <= MODE_WAIT;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            hex_count_ff  <= hex_count_in;
            code_point_ff <= code_point_in;
         end
      end
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         end_ff  <= in_end;
      end
   end

   `JSU_ASSERT_NEXT(a_end_returns_to_wait, clock, reset, advance && end_ff, mode_ff == MODE_WAIT, "text end did not return the parser to waiting")
   `JSU_ASSERT_NEXT(a_stalled_item_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(byte_ff) && $stable(mode_ff), "stalled item or parse state changed")
   `JSU_ASSERT_SAME(a_ready_when_empty, clock, reset, !s1_valid_ff, in_ready, "empty input stage refused an item")

endmodule

[rtl/core/jsu_out.sv]
// ----------------------------------------------------------------------------
// JSON string unescape unit: result buffer
// Holds the results of one item and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_out import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        bun_valid,
   output logic        bun_ready,
   input  bundle_type  bun,
   output logic        out_valid,
   input  logic        out_ready,
   output status_type  out_status,
   output logic [7:0]  out_data,
   output logic        out_last
);

   logic       buf_valid_ff;
   bundle_type buf_ff;
   logic [1:0] idx_ff;
   logic       at_last;
   logic       take;

   assign at_last   = ({1'b0, idx_ff} + 3'd1) == buf_ff.count;
   assign take      = buf_valid_ff && out_ready;
   assign bun_ready = !buf_valid_ff || (out_ready && at_last);

   assign out_valid  = buf_valid_ff;
   assign out_status = buf_ff.res[idx_ff].status;
   assign out_data   = buf_ff.res[idx_ff].data;
   assign out_last   = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (bun_valid && bun_ready) begin
         buf_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (take && at_last) begin
         buf_valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
      if (bun_valid && bun_ready) begin
         buf_ff <= bun;
      end
   end

   `JSU_ASSERT_SAME(a_index_in_range, clock, reset, buf_valid_ff, ({1'b0, idx_ff} < buf_ff.count) && (buf_ff.count <= 3'd4), "result index outside the buffered count")
   `JSU_ASSERT_SAME(a_report_is_last, clock, reset, out_valid && (out_status != ST_DATA), out_last && (out_data == 8'd0), "status report not last or not zero")
   `JSU_ASSERT_NEXT(a_hold_on_stall, clock, reset, out_valid && !out_ready, out_valid && $stable(idx_ff), "result advanced without being taken")

endmodule

[rtl/core/json_string_unescape_utf8_unit.sv]
// ----------------------------------------------------------------------------
// JSON string unescape unit: top level
// A result passes through the input register and then the result buffer.
// Throughput: one item per cycle while each item yields at most one result and
// the receiver is ready; an item that yields several results (up to four)
// holds the result port while the single result register hands them out in turn.
// Reset (synchronous, active high) empties both stages and sets the parser
// to wait for an opening quote with no hex digits collected.
// ----------------------------------------------------------------------------
//
// The decoder holds one input item in a register and decodes it against the
// parse state (waiting, inside the string, after a backslash, collecting hex)
// in one pass of short logic. Every result that the item causes, up to three
// UTF-8 data bytes and one status report, is loaded at once into the result
// buffer. The buffer shows them in order and raises tlast on the final one,
// and it reloads in the same cycle that its last result is taken, so the
// stream does not stall on single-result items. Items that cause no result,
// such as an opening quote or a backslash, update the state and vanish.

module json_string_unescape_utf8_unit import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_of_run
);

   bundle_type bun;
   logic       bun_valid;
   logic       bun_ready;
   status_type rsp_status;

   jsu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .bun_valid (bun_valid),
      .bun_ready (bun_ready),
      .bun       (bun)
   );

   jsu_out u_out (
      .clock      (clock),
      .reset      (reset),
      .bun_valid  (bun_valid),
      .bun_ready  (bun_ready),
      .bun        (bun),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_status),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

   // The status enum travels on the sideband as its plain code.
   assign rsp_tuser = rsp_status;

endmodule

[tb/json_string_unescape_utf8_unit_test.sv]
// ----------------------------------------------------------------------------
// JSON string unescape unit: self-checking testbench
// Streams text bytes into the unit and checks every decoded item against an
// in-bench decoder. A short table of hand-picked items comes first. Random
// string literals follow, most of them well formed, with noise, truncated
// text and bad hex escapes mixed in, under several sender and receiver
// idling patterns.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_test import jsu_pkg::*;;

   // Parser modes of the in-bench decoder, in the order the unit walks them.
   typedef enum logic [1:0] {
      PARSE_WAIT   = 2'd0,
      PARSE_TEXT   = 2'd1,
      PARSE_ESCAPE = 2'd2,
      PARSE_HEX    = 2'd3
   } parse_mode_type;

   // One decoded item as it should leave the result port.
   typedef struct packed {
      status_type  status;
      logic [7:0]  data;
      logic        last;
   } decoded_type;

   // One raw text byte with its end-of-text flag.
   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
   } text_item_type;

   // A row of the opening table. Where typed is set, the row causes exactly
   // one result and that result is written out here instead of predicted.
   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
      logic        typed;
      status_type  st;
      logic [7:0]  data;
   } opening_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 4;
   localparam int PHASE_ITEMS    = 45;
   localparam int DRAIN_CYCLES   = 8;
   localparam int OPENING_ROWS   = 25;

   // ASCII bounds of the hex digits.
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPERA = 8'h41;
   localparam logic [7:0] CH_UPPERF = 8'h46;
   localparam logic [7:0] CH_LOWERA = 8'h61;
   localparam logic [7:0] CH_LOWERF = 8'h66;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] text_byte
   logic        req_tlast = 1'b0;     // text_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] out_byte
   logic [1:0]  rsp_tuser;            // [1:0] status
   logic        rsp_tlast;            // last_of_run

   // State of the in-bench decoder; it starts where the unit's reset leaves it.
   parse_mode_type parse_mode = PARSE_WAIT;
   logic [1:0]     digits_seen = 2'd0;
   logic [15:0]    code_acc = 16'h0000;

   decoded_type    step_output[$];     // results of the item just decoded
   decoded_type    due_output[$];      // results still owed by the unit
   text_item_type  text_queue[$];      // text composed but not yet sent

   int unsigned    mismatch_count = 0;
   int unsigned    quiet_cycles = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;

   // Idling per random phase: none, sender only, receiver only, then both.
   int sender_idle_by_phase [PHASE_COUNT]    = '{0, 65, 0, 10};
   int receiver_stall_by_phase [PHASE_COUNT] = '{0, 0, 65, 10};

   // Code points on the borders of the UTF-8 lengths and of the surrogates.
   logic [15:0] border_points [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                      16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

   // The opening table: missing quote with both byte extremes, a data byte,
   // an escape, a surrogate and a three-byte code point, a bad hex digit,
   // text ending right after a backslash, and a close on the final byte.
   opening_row_type opening_rows [OPENING_ROWS] = '{
      '{8'h00,     1'b0, 1'b1, ST_ERR,  8'h00},
      '{8'hFF,     1'b1, 1'b1, ST_ERR,  8'h00},
      '{CH_QUOTE,  1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'hFF,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_BSLASH, 1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_N,      1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_BSLASH, 1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_U,      1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h44,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h38,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h30,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h30,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_BSLASH, 1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_U,      1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h66,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h46,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h46,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h66,     1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_BSLASH, 1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_U,      1'b0, 1'b0, ST_DATA, 8'h00},
      '{8'h67,     1'b0, 1'b1, ST_ERR,  8'h00},
      '{CH_QUOTE,  1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_BSLASH, 1'b1, 1'b1, ST_ERR,  8'h00},
      '{CH_QUOTE,  1'b0, 1'b0, ST_DATA, 8'h00},
      '{CH_QUOTE,  1'b1, 1'b1, ST_OK,   8'h00}
   };

   json_string_unescape_utf8_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // In-bench decoder.
   // ------------------------------------------------------------------------

   function automatic void add_result(status_type st, logic [7:0] d);
      decoded_type r;
      r.status = st;
      r.data   = d;
      r.last   = 1'b0;
      step_output.push_back(r);
   endfunction

   // Returns the value of a hex digit in either case, or -1 for any other byte.
   function automatic int hex_nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LOWERA && c <= CH_LOWERF) return int'(c - CH_LOWERA) + 10;
      if (c >= CH_UPPERA && c <= CH_UPPERF) return int'(c - CH_UPPERA) + 10;
      return -1;
   endfunction

   // Decodes one text byte against the parser state and leaves the results
   // it causes in step_output, with the last flag on the final one.
   function automatic void decode_text_byte(logic [7:0] c, logic fin);
      logic closed;
      int   nib;
      closed = 1'b0;
      step_output.delete();
      case (parse_mode)
         PARSE_WAIT: begin
            if (c == CH_QUOTE) begin
               parse_mode = PARSE_TEXT;
            end else begin
               add_result(ST_ERR, 8'h00);
               closed = 1'b1;
            end
         end
         PARSE_TEXT: begin
            if (c == CH_QUOTE) begin
               add_result(ST_OK, 8'h00);
               parse_mode = PARSE_WAIT;
               closed = 1'b1;
            end else if (c == CH_BSLASH) begin
               parse_mode = PARSE_ESCAPE;
            end else begin
               add_result(ST_DATA, c);
            end
         end
         PARSE_ESCAPE: begin
            parse_mode = PARSE_TEXT;
            case (c)
               CH_N: add_result(ST_DATA, CH_LF);
               CH_R: add_result(ST_DATA, CH_CR);
               CH_T: add_result(ST_DATA, CH_TAB);
               CH_B: add_result(ST_DATA, CH_BS);
               CH_F: add_result(ST_DATA, CH_FF);
               CH_U: begin
                  parse_mode  = PARSE_HEX;
                  digits_seen = 2'd0;
                  code_acc    = 16'h0000;
               end
               default: add_result(ST_DATA, c);
            endcase
         end
         default: begin
            nib = hex_nibble(c);
            if (nib < 0) begin
               add_result(ST_ERR, 8'h00);
               parse_mode = PARSE_WAIT;
               closed = 1'b1;
            end else begin
               code_acc = {code_acc[11:0], 4'(nib)};
               if (digits_seen == 2'd3) begin
                  // Fourth digit: the code point is complete, emit its UTF-8 form.
                  if (code_acc < CP_TWO_BYTE) begin
                     add_result(ST_DATA, code_acc[7:0]);
                  end else if (code_acc < CP_THREE_BYTE) begin
                     add_result(ST_DATA, UTF8_LEAD2 | 8'(code_acc >> 6));
                     add_result(ST_DATA, UTF8_CONT | (code_acc[7:0] & UTF8_MASK6));
                  end else if (code_acc >= CP_SURR_LO && code_acc <= CP_SURR_HI) begin
                     add_result(ST_DATA, CH_QMARK);
                  end else begin
                     add_result(ST_DATA, UTF8_LEAD3 | {4'h0, code_acc[15:12]});
                     add_result(ST_DATA, UTF8_CONT | {2'b00, code_acc[11:6]});
                     add_result(ST_DATA, UTF8_CONT | (code_acc[7:0] & UTF8_MASK6));
                  end
                  digits_seen = 2'd0;
                  parse_mode  = PARSE_TEXT;
               end else begin
                  digits_seen = digits_seen + 2'd1;
               end
            end
         end
      endcase
      // Text that ends anywhere but on a report gets an error after its data.
      if (fin && !closed) begin
         add_result(ST_ERR, 8'h00);
         parse_mode = PARSE_WAIT;
      end
      if (step_output.size() > 0) step_output[step_output.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Text composition for the random part.
   // ------------------------------------------------------------------------

   function automatic void push_text(logic [7:0] c, logic fin);
      text_item_type t;
      t.ch  = c;
      t.fin = fin;
      text_queue.push_back(t);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return CH_ZERO + {4'h0, v};
      if ($urandom_range(0, 1) == 0) return CH_LOWERA + {4'h0, v} - 8'd10;
      return CH_UPPERA + {4'h0, v} - 8'd10;
   endfunction

   function automatic logic [15:0] pick_code_point();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 'h7F));
         1: return 16'($urandom_range('h80, 'h7FF));
         2: return 16'($urandom_range('hD800, 'hDFFF));
         3: return 16'($urandom_range('h800, 'hFFFF));
         4: return border_points[$urandom_range(0, 7)];
         default: return 16'($urandom_range(0, 'hFFFF));
      endcase
   endfunction

   // Appends one piece of string content: a plain byte, a control escape,
   // a literal escape, or a unicode escape.
   function automatic void add_token();
      logic [7:0]  c;
      logic [15:0] cp;
      case ($urandom_range(0, 5))
         0, 1: begin
            c = 8'($urandom_range(0, 255));
            // Flip the top bit so a plain byte never ends or escapes the string.
            if (c == CH_QUOTE || c == CH_BSLASH) c = c ^ 8'h80;
            push_text(c, 1'b0);
         end
         2: begin
            push_text(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 4))
               0: push_text(CH_N, 1'b0);
               1: push_text(CH_R, 1'b0);
               2: push_text(CH_T, 1'b0);
               3: push_text(CH_B, 1'b0);
               default: push_text(CH_F, 1'b0);
            endcase
         end
         3: begin
            push_text(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 3))
               0: c = CH_QUOTE;
               1: c = CH_BSLASH;
               default: begin
                  c = 8'($urandom_range(0, 255));
                  if (c == CH_U) c = CH_QUOTE;
               end
            endcase
            push_text(c, 1'b0);
         end
         default: begin
            cp = pick_code_point();
            push_text(CH_BSLASH, 1'b0);
            push_text(CH_U, 1'b0);
            push_text(hex_char(cp[15:12]), 1'b0);
            push_text(hex_char(cp[11:8]), 1'b0);
            push_text(hex_char(cp[7:4]), 1'b0);
            push_text(hex_char(cp[3:0]), 1'b0);
         end
      endcase
   endfunction

   // Composes one text: mostly a well-formed literal, otherwise stray bytes,
   // a literal cut short by the end flag, or a unicode escape with a bad digit.
   function automatic void compose_text();
      int         kind;
      int         cut;
      logic [7:0] bad;
      kind = int'($urandom_range(0, 99));
      if (kind < 12) begin
         repeat ($urandom_range(1, 3))
            push_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
         push_text(CH_QUOTE, 1'b0);
         repeat ($urandom_range(0, 6)) add_token();
         if (kind < 80) begin
            push_text(CH_QUOTE, 1'($urandom_range(0, 1)));
         end else if (kind < 90) begin
            push_text(CH_QUOTE, 1'b0);
            cut = int'($urandom_range(0, text_queue.size() - 2));
            while (text_queue.size() > cut + 1) void'(text_queue.pop_back());
            text_queue[cut].fin = 1'b1;
         end else begin
            push_text(CH_BSLASH, 1'b0);
            push_text(CH_U, 1'b0);
            repeat ($urandom_range(0, 3)) push_text(hex_char(4'($urandom_range(0, 15))), 1'b0);
            do bad = 8'($urandom_range(0, 255)); while (hex_nibble(bad) >= 0);
            push_text(bad, 1'b0);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------------

   // Offers one text byte, waits for the handshake, then records what the
   // unit owes for it: either the typed-in result or the decoder's results.
   task automatic drive_text_byte(text_item_type it, logic typed, decoded_type typed_res);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tlast  <= it.fin;
      do @(posedge clock); while (!req_tready);
      decode_text_byte(it.ch, it.fin);
      if (typed) begin
         due_output.push_back(typed_res);
      end else begin
         foreach (step_output[i]) due_output.push_back(step_output[i]);
      end
   endtask

   // Holds the sender off until every owed result has come out.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_output.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side and checking.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Each accepted result is compared with the oldest owed result.
   always @(posedge clock) begin : check_output
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_output.size() == 0) begin
            report_mismatch("unowed result, data", rsp_tdata, 8'h00);
         end else begin
            want = due_output.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", {6'b0, rsp_tuser}, {6'b0, want.status});
            if (rsp_tdata != want.data)
               report_mismatch("out_byte", rsp_tdata, want.data);
            if (rsp_tlast != want.last)
               report_mismatch("last_of_run", {7'b0, rsp_tlast}, {7'b0, want.last});
         end
      end
   end

   // The watchdog ends a run in which neither port has moved an item for
   // far longer than any idling pattern here can explain.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL json_string_unescape_utf8_unit");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------

   initial begin : run_test
      text_item_type it;
      decoded_type   typed_res;
      int            sent;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Opening table, sent back to back with the receiver always ready.
      foreach (opening_rows[i]) begin
         it.ch            = opening_rows[i].ch;
         it.fin           = opening_rows[i].fin;
         typed_res.status = opening_rows[i].st;
         typed_res.data   = opening_rows[i].data;
         typed_res.last   = 1'b1;
         drive_text_byte(it, opening_rows[i].typed, typed_res);
      end
      wait_for_drain();

      // Random texts in phases of different idling. Each phase ends with the
      // sender held off until the unit has delivered all it owes.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct    = sender_idle_by_phase[phase];
         receiver_stall_pct = receiver_stall_by_phase[phase];
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            compose_text();
            while (text_queue.size() != 0) begin
               drive_text_byte(text_queue.pop_front(), 1'b0, '0);
               sent++;
            end
         end
         wait_for_drain();
      end

      // Let any stray results show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_output.size() == 0) begin
         $display("PASS json_string_unescape_utf8_unit");
      end else begin
         $display("FAIL json_string_unescape_utf8_unit");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_out.sv
rtl/core/json_string_unescape_utf8_unit.sv
tb/json_string_unescape_utf8_unit_test.sv
